>>> rtl/pce_pkg.sv
// ----------------------------------------------------------------------------
// pce_pkg
// Shared types, letter codes and grid arithmetic for the playfair engine.
// ----------------------------------------------------------------------------
package pce_pkg;

	localparam int GRID_SIDE   = 5;
	localparam int SQUARE_SIZE = GRID_SIDE * GRID_SIDE;
	localparam int NUM_LETTERS = 26;
	localparam int LETTER_W    = 5;
	localparam int POS_W       = $clog2(SQUARE_SIZE);
	localparam int COORD_W     = $clog2(GRID_SIDE);

	typedef logic [LETTER_W-1:0] letter_t;
	typedef logic [POS_W-1:0]    pos_t;
	typedef logic [COORD_W-1:0]  coord_t;

	localparam logic [2:0] ACT_KEY_START  = 3'd0;
	localparam logic [2:0] ACT_KEY_LETTER = 3'd1;
	localparam logic [2:0] ACT_KEY_FINISH = 3'd2;
	localparam logic [2:0] ACT_MSG_LETTER = 3'd3;
	localparam logic [2:0] ACT_MSG_END    = 3'd4;

	localparam letter_t CODE_I = letter_t'(8);
	localparam letter_t CODE_J = letter_t'(9);
	localparam letter_t CODE_Q = letter_t'(16);
	localparam letter_t CODE_X = letter_t'(23);
	localparam letter_t CODE_Z = letter_t'(25);
	localparam letter_t LAST_LETTER = letter_t'(NUM_LETTERS - 1);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_FILL,
		ST_LOOK,
		ST_SQUARE
	} state_t;

	function automatic coord_t pos_row(pos_t p);
		coord_t r;
		r = '0;
		for (int i = 1; i < GRID_SIDE; i++) begin
			if (p >= pos_t'(i * GRID_SIDE))
				r = coord_t'(i);
		end
		return r;
	endfunction

	function automatic coord_t pos_col(pos_t p);
		pos_t base;
		base = pos_t'(int'(pos_row(p)) * GRID_SIDE);
		return coord_t'(p - base);
	endfunction

	// one step round the row or column, backwards when decrypting
	function automatic coord_t step_coord(coord_t c, logic dec);
		coord_t r;
		if (dec)
			r = (c == '0) ? coord_t'(GRID_SIDE - 1) : coord_t'(c - coord_t'(1));
		else
			r = (c == coord_t'(GRID_SIDE - 1)) ? '0 : coord_t'(c + coord_t'(1));
		return r;
	endfunction

	function automatic pos_t pos_of(coord_t r, coord_t c);
		return pos_t'(int'(r) * GRID_SIDE) + pos_t'(c);
	endfunction

endpackage

>>> rtl/playfair_cipher_engine_core.sv
// ----------------------------------------------------------------------------
// playfair_cipher_engine_core
// Streaming 5x5 playfair cipher with the square held in on-chip memories.
// ----------------------------------------------------------------------------
// Input channel (in_valid / in_stall) carries one word: an action code and a
// letter (A=0 .. Z=25). Output channel (out_valid / out_stall) carries one
// cipher letter per word; a pair is two words, last_in_pair marking the
// second and message_done marking the second word of the pair that message
// end produces. cfg_valid / cfg_ready writes cipher_mode (0 encrypt, 1
// decrypt); cfg_ready is always high and writes belong to idle periods.
// Key start, key letter, message letters that only get held and message end
// with nothing held are handled while idle. Key finish walks the alphabet
// through the square memory, one letter a cycle. A letter or message end that
// completes a pair goes through a read of the position memory, then a read
// of the square memory, then the pair moves into the output buffer; the first
// word is offered on the cycle after that. The next word is accepted while
// the previous pair still drains, but a new pair waits in the last step until
// the buffer is empty. A stalled receiver holds the buffered word unchanged.
// Reset clears the key (not ready), the held letter, the mode and the
// output buffer; the memories keep whatever they hold until written.
// ----------------------------------------------------------------------------
module playfair_cipher_engine_core (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_valid,
	output logic       cfg_ready,
	input  logic       cfg_data,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [2:0] action,
	input  logic [4:0] letter_in,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [4:0] cipher_letter,
	output logic       last_in_pair,
	output logic       message_done
);

	pce_pkg::state_t state_q, state_d;

	logic                             cipher_mode_q;
	logic [pce_pkg::NUM_LETTERS-1:0]  used_q;
	pce_pkg::pos_t                    fill_q;
	logic                             key_ready_q;
	pce_pkg::letter_t                 held_letter_q;
	logic                             held_valid_q;
	pce_pkg::letter_t                 walk_q;
	logic                             done_q;

	logic                             out_valid_q;
	logic                             out_second_q;
	pce_pkg::letter_t                 out_first_letter_q;
	pce_pkg::letter_t                 out_second_letter_q;
	logic                             out_done_q;

	pce_pkg::letter_t square_mem [pce_pkg::SQUARE_SIZE];
	pce_pkg::pos_t    place_mem  [pce_pkg::NUM_LETTERS];

	pce_pkg::pos_t    place_a_s1, place_b_s1;
	pce_pkg::letter_t sq_a_s2, sq_b_s2;

	logic             accept;
	pce_pkg::letter_t code;
	logic             code_ok;
	logic             square_full;
	logic             enc_start;
	pce_pkg::letter_t partner;

	logic             place_en;
	pce_pkg::letter_t place_code;
	logic             place_rd_en;
	logic             sq_rd_en;
	logic             load_out;

	pce_pkg::coord_t  r1, c1, r2, c2;
	pce_pkg::coord_t  nr1, nc1, nr2, nc2;
	pce_pkg::pos_t    sq_addr_a, sq_addr_b;

	assign cfg_ready = 1'b1;

	// common decode
	assign accept      = in_valid && !in_stall;
	assign code        = (letter_in == pce_pkg::CODE_J) ? pce_pkg::CODE_I : letter_in;
	assign code_ok     = code <= pce_pkg::LAST_LETTER;
	assign square_full = fill_q >= pce_pkg::pos_t'(pce_pkg::SQUARE_SIZE);

	always_comb begin
		enc_start = 1'b0;
		if (accept && key_ready_q && held_valid_q) begin
			if (action == pce_pkg::ACT_MSG_END)
				enc_start = 1'b1;
			else if (action == pce_pkg::ACT_MSG_LETTER && code_ok)
				enc_start = 1'b1;
		end
	end

	always_comb begin
		if (action == pce_pkg::ACT_MSG_END)
			partner = pce_pkg::CODE_Z;
		else if (held_letter_q != code)
			partner = code;
		else if (held_letter_q == pce_pkg::CODE_X)
			partner = pce_pkg::CODE_Q;
		else
			partner = pce_pkg::CODE_X;
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			pce_pkg::ST_IDLE: begin
				if (accept && action == pce_pkg::ACT_KEY_FINISH && !key_ready_q)
					state_d = pce_pkg::ST_FILL;
				else if (enc_start)
					state_d = pce_pkg::ST_LOOK;
			end
			pce_pkg::ST_FILL: begin
				if (walk_q == pce_pkg::LAST_LETTER)
					state_d = pce_pkg::ST_IDLE;
			end
			pce_pkg::ST_LOOK: begin
				state_d = pce_pkg::ST_SQUARE;
			end
			pce_pkg::ST_SQUARE: begin
				if (!out_valid_q)
					state_d = pce_pkg::ST_IDLE;
			end
			default: begin
				state_d = pce_pkg::ST_IDLE;
			end
		endcase
	end

	// state outputs
	always_comb begin
		in_stall    = 1'b1;
		place_en    = 1'b0;
		place_code  = code;
		place_rd_en = 1'b0;
		sq_rd_en    = 1'b0;
		load_out    = 1'b0;
		case (state_q)
			pce_pkg::ST_IDLE: begin
				in_stall    = 1'b0;
				place_rd_en = enc_start;
				if (accept && action == pce_pkg::ACT_KEY_LETTER && !key_ready_q && code_ok)
					place_en = !used_q[code] && !square_full;
			end
			pce_pkg::ST_FILL: begin
				place_code = walk_q;
				place_en   = (walk_q != pce_pkg::CODE_J) && !used_q[walk_q] && !square_full;
			end
			pce_pkg::ST_LOOK: begin
				sq_rd_en = 1'b1;
			end
			pce_pkg::ST_SQUARE: begin
				load_out = !out_valid_q;
			end
			default: begin
				in_stall = 1'b1;
			end
		endcase
	end

	// pair rule on the two positions
	always_comb begin
		r1  = pce_pkg::pos_row(place_a_s1);
		c1  = pce_pkg::pos_col(place_a_s1);
		r2  = pce_pkg::pos_row(place_b_s1);
		c2  = pce_pkg::pos_col(place_b_s1);
		nr1 = r1;
		nr2 = r2;
		nc1 = c2;
		nc2 = c1;
		if (r1 == r2) begin
			nc1 = pce_pkg::step_coord(c1, cipher_mode_q);
			nc2 = pce_pkg::step_coord(c2, cipher_mode_q);
		end else if (c1 == c2) begin
			nr1 = pce_pkg::step_coord(r1, cipher_mode_q);
			nr2 = pce_pkg::step_coord(r2, cipher_mode_q);
			nc1 = c1;
			nc2 = c2;
		end
		sq_addr_a = pce_pkg::pos_of(nr1, nc1);
		sq_addr_b = pce_pkg::pos_of(nr2, nc2);
	end

	// square and position memories
	always_ff @(posedge clk) begin
		if (place_en) begin
			square_mem[fill_q]    <= place_code;
			place_mem[place_code] <= fill_q;
		end
	end

	always_ff @(posedge clk) begin
		if (place_rd_en) begin
			place_a_s1 <= place_mem[held_letter_q];
			place_b_s1 <= place_mem[partner];
		end
		if (sq_rd_en) begin
			sq_a_s2 <= square_mem[sq_addr_a];
			sq_b_s2 <= square_mem[sq_addr_b];
		end
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= pce_pkg::ST_IDLE;
			cipher_mode_q <= 1'b0;
			used_q        <= '0;
			fill_q        <= '0;
			key_ready_q   <= 1'b0;
			held_letter_q <= '0;
			held_valid_q  <= 1'b0;
			walk_q        <= '0;
			out_valid_q   <= 1'b0;
			out_second_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_valid && cfg_ready)
				cipher_mode_q <= cfg_data;

			if (accept && action == pce_pkg::ACT_KEY_START) begin
				used_q       <= '0;
				fill_q       <= '0;
				key_ready_q  <= 1'b0;
				held_valid_q <= 1'b0;
			end else if (place_en) begin
				used_q[place_code] <= 1'b1;
				fill_q             <= fill_q + pce_pkg::pos_t'(1);
			end

			if (state_q == pce_pkg::ST_IDLE)
				walk_q <= '0;
			else if (state_q == pce_pkg::ST_FILL)
				walk_q <= walk_q + pce_pkg::letter_t'(1);
			if (state_q == pce_pkg::ST_FILL && walk_q == pce_pkg::LAST_LETTER)
				key_ready_q <= 1'b1;

			if (accept && key_ready_q) begin
				if (action == pce_pkg::ACT_MSG_LETTER && code_ok) begin
					if (!held_valid_q) begin
						held_letter_q <= code;
						held_valid_q  <= 1'b1;
					end else if (held_letter_q != code) begin
						held_valid_q <= 1'b0;
					end
				end else if (action == pce_pkg::ACT_MSG_END) begin
					held_valid_q <= 1'b0;
				end
			end

			if (load_out) begin
				out_valid_q  <= 1'b1;
				out_second_q <= 1'b0;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q  <= !out_second_q;
				out_second_q <= !out_second_q;
			end
		end
	end

	// pair payload
	always_ff @(posedge clk) begin
		if (enc_start)
			done_q <= (action == pce_pkg::ACT_MSG_END);
		if (load_out) begin
			out_first_letter_q  <= sq_a_s2;
			out_second_letter_q <= sq_b_s2;
			out_done_q          <= done_q;
		end
	end

	assign out_valid     = out_valid_q;
	assign cipher_letter = out_second_q ? out_second_letter_q : out_first_letter_q;
	assign last_in_pair  = out_second_q;
	assign message_done  = out_second_q && out_done_q;

	// checks
	a_fill_not_ready: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == pce_pkg::ST_FILL |-> !key_ready_q)
		else $error("alphabet walk with key already ready");

	a_ready_full: assert property (@(posedge clk) disable iff (!arst_n)
		key_ready_q |-> fill_q == pce_pkg::pos_t'(pce_pkg::SQUARE_SIZE))
		else $error("key ready with square not full");

	a_used_count: assert property (@(posedge clk) disable iff (!arst_n)
		$countones(used_q) == int'(fill_q))
		else $error("used letters disagree with fill count");

	a_lookup_keyed: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == pce_pkg::ST_LOOK |-> key_ready_q && $past(place_rd_en))
		else $error("pair lookup without a ready key");

	a_held_not_j: assert property (@(posedge clk) disable iff (!arst_n)
		held_valid_q |-> held_letter_q != pce_pkg::CODE_J)
		else $error("held letter is J");

endmodule

>>> sim/playfair_cipher_engine_core_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// playfair_cipher_engine_core_tb
// Self-checking bench for the streaming playfair engine. A short table of
// directed words (known squares, doubled letters, padding, dropped and
// out-of-range letters) is followed by random key and message sessions in
// both cipher modes. An in-bench model of the square predicts every output
// word the table does not type, and both channels see random gaps and stalls.
// ----------------------------------------------------------------------------
module playfair_cipher_engine_core_tb;

	localparam logic [2:0] ACT_SPARE = 3'd7;
	localparam int SETTLE_CYCLES = 40;
	localparam int IDLE_LIMIT    = 1000;

	typedef struct {
		pce_pkg::letter_t ltr;
		bit               second;
		bit               done;
	} cipher_word_t;

	typedef struct {
		logic [2:0]       act;
		pce_pkg::letter_t ltr;
		bit               typed;
		int               n;
		pce_pkg::letter_t first;
		pce_pkg::letter_t second;
	} vector_t;

	logic       clk = 1'b0;
	logic       arst_n;
	logic       cfg_valid;
	logic       cfg_ready;
	logic       cfg_data;
	logic       in_valid;
	logic       in_stall;
	logic [2:0] action;
	logic [4:0] letter_in;
	logic       out_valid;
	logic       out_stall = 1'b0;
	logic [4:0] cipher_letter;
	logic       last_in_pair;
	logic       message_done;

	// model of the square
	pce_pkg::letter_t square_at [pce_pkg::SQUARE_SIZE];
	int               place_of [pce_pkg::NUM_LETTERS];
	bit               placed [pce_pkg::NUM_LETTERS];
	int               fill_pos;
	bit               key_done;
	pce_pkg::letter_t held;
	bit               holding;
	bit               decrypt;

	cipher_word_t new_words[$];
	cipher_word_t due_words[$];
	vector_t      vectors [29];

	int fail_count = 0;
	int idle_cycles = 0;
	int quiet_in = 0;
	int stall_run = 0;
	int calm_run = 0;

	always #10 clk = ~clk;

	playfair_cipher_engine_core u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_data     (cfg_data),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.action       (action),
		.letter_in    (letter_in),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.cipher_letter(cipher_letter),
		.last_in_pair (last_in_pair),
		.message_done (message_done)
	);

	function automatic cipher_word_t make_word(pce_pkg::letter_t l, bit sec, bit done);
		cipher_word_t w;
		w.ltr = l;
		w.second = sec;
		w.done = done;
		return w;
	endfunction

	function automatic void place_letter(int code);
		if (code >= pce_pkg::NUM_LETTERS || placed[code] || fill_pos >= pce_pkg::SQUARE_SIZE)
			return;
		square_at[fill_pos] = pce_pkg::letter_t'(code);
		place_of[code] = fill_pos;
		placed[code] = 1'b1;
		fill_pos++;
	endfunction

	function automatic void encode_pair(pce_pkg::letter_t a, pce_pkg::letter_t b, bit done);
		int sh, r1, c1, r2, c2, t;
		sh = decrypt ? pce_pkg::GRID_SIDE - 1 : 1;
		r1 = place_of[a] / pce_pkg::GRID_SIDE;
		c1 = place_of[a] % pce_pkg::GRID_SIDE;
		r2 = place_of[b] / pce_pkg::GRID_SIDE;
		c2 = place_of[b] % pce_pkg::GRID_SIDE;
		if (r1 == r2) begin
			c1 = (c1 + sh) % pce_pkg::GRID_SIDE;
			c2 = (c2 + sh) % pce_pkg::GRID_SIDE;
		end else if (c1 == c2) begin
			r1 = (r1 + sh) % pce_pkg::GRID_SIDE;
			r2 = (r2 + sh) % pce_pkg::GRID_SIDE;
		end else begin
			t = c1;
			c1 = c2;
			c2 = t;
		end
		new_words.push_back(make_word(square_at[r1 * pce_pkg::GRID_SIDE + c1], 1'b0, 1'b0));
		new_words.push_back(make_word(square_at[r2 * pce_pkg::GRID_SIDE + c2], 1'b1, done));
	endfunction

	function automatic void encipher_step(logic [2:0] act, pce_pkg::letter_t l);
		pce_pkg::letter_t c;
		new_words.delete();
		c = (l == pce_pkg::CODE_J) ? pce_pkg::CODE_I : l;
		case (act)
			pce_pkg::ACT_KEY_START: begin
				foreach (placed[i])
					placed[i] = 1'b0;
				fill_pos = 0;
				key_done = 1'b0;
				holding = 1'b0;
			end
			pce_pkg::ACT_KEY_LETTER: begin
				if (!key_done)
					place_letter(int'(c));
			end
			pce_pkg::ACT_KEY_FINISH: begin
				for (int i = 0; i < pce_pkg::NUM_LETTERS; i++)
					if (i != int'(pce_pkg::CODE_J))
						place_letter(i);
				key_done = 1'b1;
			end
			pce_pkg::ACT_MSG_LETTER: begin
				if (key_done && int'(c) < pce_pkg::NUM_LETTERS) begin
					if (!holding) begin
						held = c;
						holding = 1'b1;
					end else if (held == c) begin
						encode_pair(held, (held == pce_pkg::CODE_X) ? pce_pkg::CODE_Q
							: pce_pkg::CODE_X, 1'b0);
					end else begin
						encode_pair(held, c, 1'b0);
						holding = 1'b0;
					end
				end
			end
			pce_pkg::ACT_MSG_END: begin
				if (key_done && holding) begin
					encode_pair(held, pce_pkg::CODE_Z, 1'b1);
					holding = 1'b0;
				end
			end
			default: ;
		endcase
	endfunction

	function automatic int pick_gap();
		int p;
		if (quiet_in > 0) begin
			quiet_in--;
			return 0;
		end
		p = $urandom_range(0, 99);
		if (p < 3) begin
			quiet_in = $urandom_range(20, 60);
			return 0;
		end
		if (p < 7)
			return $urandom_range(8, 30);
		if (p < 40)
			return $urandom_range(1, 3);
		return 0;
	endfunction

	function automatic pce_pkg::letter_t key_letter();
		int p;
		p = $urandom_range(0, 99);
		if (p < 8)
			return pce_pkg::CODE_J;
		if (p < 14)
			return pce_pkg::letter_t'($urandom_range(pce_pkg::NUM_LETTERS, 31));
		return pce_pkg::letter_t'($urandom_range(0, pce_pkg::NUM_LETTERS - 1));
	endfunction

	function automatic pce_pkg::letter_t msg_letter(pce_pkg::letter_t prev);
		int p;
		p = $urandom_range(0, 99);
		if (p < 25)
			return prev;
		if (p < 33)
			return pce_pkg::CODE_X;
		if (p < 38)
			return pce_pkg::CODE_J;
		if (p < 42)
			return pce_pkg::letter_t'($urandom_range(pce_pkg::NUM_LETTERS, 31));
		return pce_pkg::letter_t'($urandom_range(0, pce_pkg::NUM_LETTERS - 1));
	endfunction

	task automatic send_word(input logic [2:0] act, input pce_pkg::letter_t ltr, input bit keep);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		action <= act;
		letter_in <= ltr;
		do @(negedge clk); while (in_stall);
		@(posedge clk);
		encipher_step(act, ltr);
		if (keep)
			foreach (new_words[i])
				due_words.push_back(new_words[i]);
	endtask

	task automatic set_mode(input bit m);
		in_valid <= 1'b0;
		while (due_words.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		cfg_valid <= 1'b1;
		cfg_data <= m;
		do @(negedge clk); while (!cfg_ready);
		@(posedge clk);
		cfg_valid <= 1'b0;
		decrypt = m;
	endtask

	task automatic send_message(output int count);
		int nm;
		pce_pkg::letter_t prev, l;
		nm = $urandom_range(1, 16);
		prev = pce_pkg::letter_t'($urandom_range(0, pce_pkg::NUM_LETTERS - 1));
		for (int i = 0; i < nm; i++) begin
			l = msg_letter(prev);
			send_word(pce_pkg::ACT_MSG_LETTER, l, 1'b1);
			prev = l;
		end
		count = nm;
		if ($urandom_range(0, 9) < 8) begin
			send_word(pce_pkg::ACT_MSG_END, pce_pkg::letter_t'($urandom), 1'b1);
			count++;
		end
	endtask

	task automatic run_traffic(input int target);
		int sent, nk, nm, p;
		sent = 0;
		while (sent < target) begin
			p = $urandom_range(0, 99);
			if (p < 75) begin
				send_word(pce_pkg::ACT_KEY_START, pce_pkg::letter_t'($urandom), 1'b1);
				nk = $urandom_range(0, 12);
				repeat (nk) send_word(pce_pkg::ACT_KEY_LETTER, key_letter(), 1'b1);
				send_word(pce_pkg::ACT_KEY_FINISH, pce_pkg::letter_t'($urandom), 1'b1);
				send_message(nm);
				sent += nk + 2 + nm;
			end else if (p < 88) begin
				send_message(nm);
				sent += nm;
			end else begin
				send_word(3'($urandom_range(0, 7)), pce_pkg::letter_t'($urandom), 1'b1);
				sent++;
			end
		end
	endtask

	// receiver back-pressure: short stalls, a few long ones, calm stretches
	always @(posedge clk) begin
		int p;
		if (calm_run > 0) begin
			calm_run <= calm_run - 1;
			out_stall <= 1'b0;
		end else if (stall_run > 0) begin
			stall_run <= stall_run - 1;
			out_stall <= 1'b1;
		end else begin
			p = $urandom_range(0, 99);
			if (p < 4) begin
				calm_run <= $urandom_range(20, 80);
				out_stall <= 1'b0;
			end else if (p < 8) begin
				stall_run <= $urandom_range(5, 40);
				out_stall <= 1'b1;
			end else begin
				out_stall <= (p < 38);
			end
		end
	end

	// output check and watchdog, sampled mid-cycle
	always @(negedge clk) begin
		cipher_word_t w;
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				if (due_words.size() == 0) begin
					$error("unexpected word: cipher_letter %0d", cipher_letter);
					fail_count++;
				end else begin
					w = due_words.pop_front();
					if (cipher_letter !== w.ltr) begin
						$error("cipher_letter: expected %0d, got %0d", w.ltr, cipher_letter);
						fail_count++;
					end
					if (last_in_pair !== w.second) begin
						$error("last_in_pair: expected %0d, got %0d", w.second, last_in_pair);
						fail_count++;
					end
					if (message_done !== w.done) begin
						$error("message_done: expected %0d, got %0d", w.done, message_done);
						fail_count++;
					end
				end
			end
			if ((in_valid && !in_stall) || (out_valid && !out_stall)
					|| (cfg_valid && cfg_ready))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("*** FAILED ***");
				$finish;
			end
		end
	end

	initial begin
		arst_n = 1'b0;
		cfg_valid = 1'b0;
		cfg_data = 1'b0;
		in_valid = 1'b0;
		action = pce_pkg::ACT_KEY_START;
		letter_in = '0;
		fill_pos = 0;
		key_done = 1'b0;
		held = '0;
		holding = 1'b0;
		decrypt = 1'b0;
		foreach (placed[i])
			placed[i] = 1'b0;

		// plain square after a bare finish: ABCDE / FGHIK / LMNOP / QRSTU / VWXYZ
		vectors = '{
			'{pce_pkg::ACT_MSG_LETTER, 5'd0,            1'b1, 0, 5'd0,  5'd0},
			'{pce_pkg::ACT_MSG_END,    5'd0,            1'b1, 0, 5'd0,  5'd0},
			'{ACT_SPARE,               5'd31,           1'b1, 0, 5'd0,  5'd0},
			'{pce_pkg::ACT_KEY_START,  5'd0,            1'b1, 0, 5'd0,  5'd0},
			'{pce_pkg::ACT_KEY_FINISH, 5'd0,            1'b1, 0, 5'd0,  5'd0},
			'{pce_pkg::ACT_MSG_LETTER, 5'd0,            1'b1, 0, 5'd0,  5'd0},
			'{pce_pkg::ACT_MSG_LETTER, 5'd1,            1'b1, 2, 5'd1,  5'd2},
			'{pce_pkg::ACT_MSG_LETTER, pce_pkg::CODE_Z, 1'b1, 0, 5'd0,  5'd0},
			'{pce_pkg::ACT_MSG_END,    5'd0,            1'b1, 2, 5'd21, 5'd21},
			'{pce_pkg::ACT_MSG_LETTER, pce_pkg::CODE_X, 1'b1, 0, 5'd0,  5'd0},
			'{pce_pkg::ACT_MSG_LETTER, pce_pkg::CODE_X, 1'b1, 2, 5'd21, 5'd18},
			'{pce_pkg::ACT_MSG_LETTER, pce_pkg::CODE_J, 1'b1, 2, 5'd24, 5'd7},
			'{pce_pkg::ACT_MSG_LETTER, 5'd0,            1'b1, 0, 5'd0,  5'd0},
			'{pce_pkg::ACT_MSG_LETTER, 5'd5,            1'b1, 2, 5'd5,  5'd11},
			'{pce_pkg::ACT_MSG_LETTER, 5'd26,           1'b1, 0, 5'd0,  5'd0},
			'{pce_pkg::ACT_MSG_LETTER, 5'd20,           1'b1, 0, 5'd0,  5'd0},
			'{pce_pkg::ACT_MSG_LETTER, 5'd31,           1'b1, 0, 5'd0,  5'd0},
			'{pce_pkg::ACT_MSG_LETTER, pce_pkg::CODE_Z, 1'b1, 2, 5'd25, 5'd4},
			'{pce_pkg::ACT_MSG_END,    5'd0,            1'b1, 0, 5'd0,  5'd0},
			'{pce_pkg::ACT_KEY_START,  5'd0,            1'b1, 0, 5'd0,  5'd0},
			'{pce_pkg::ACT_KEY_LETTER, pce_pkg::CODE_J, 1'b1, 0, 5'd0,  5'd0},
			'{pce_pkg::ACT_KEY_LETTER, 5'd31,           1'b1, 0, 5'd0,  5'd0},
			'{pce_pkg::ACT_KEY_LETTER, pce_pkg::CODE_Z, 1'b1, 0, 5'd0,  5'd0},
			'{pce_pkg::ACT_KEY_LETTER, pce_pkg::CODE_I, 1'b1, 0, 5'd0,  5'd0},
			'{pce_pkg::ACT_KEY_FINISH, 5'd0,            1'b1, 0, 5'd0,  5'd0},
			'{pce_pkg::ACT_KEY_LETTER, 5'd0,            1'b1, 0, 5'd0,  5'd0},
			'{pce_pkg::ACT_MSG_LETTER, pce_pkg::CODE_Q, 1'b0, 0, 5'd0,  5'd0},
			'{pce_pkg::ACT_MSG_LETTER, pce_pkg::CODE_Q, 1'b0, 0, 5'd0,  5'd0},
			'{pce_pkg::ACT_MSG_END,    5'd0,            1'b0, 0, 5'd0,  5'd0}
		};

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (vectors[k]) begin
			send_word(vectors[k].act, vectors[k].ltr, !vectors[k].typed);
			if (vectors[k].typed && vectors[k].n == 2) begin
				due_words.push_back(make_word(vectors[k].first, 1'b0, 1'b0));
				due_words.push_back(make_word(vectors[k].second, 1'b1,
					vectors[k].act == pce_pkg::ACT_MSG_END));
			end
		end

		set_mode(1'b1);
		run_traffic(175);
		set_mode(1'b0);
		run_traffic(175);
		set_mode(1'b1);
		run_traffic(175);

		in_valid <= 1'b0;
		while (due_words.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (fail_count == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule

>>> playfair_cipher_engine_core.f
rtl/pce_pkg.sv
rtl/playfair_cipher_engine_core.sv
sim/playfair_cipher_engine_core_tb.sv
